[src/csi_pkg.sv]
package csi_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);

  localparam logic [STACK_AW-1:0] SP_RESET = STACK_AW'(8'hFD);

  localparam logic [7:0] BIT_ZERO   = 8'h02;
  localparam logic [7:0] BIT_BREAK  = 8'h10;
  localparam logic [7:0] BIT_UNUSED = 8'h20;
  localparam logic [7:0] BIT_NEG    = 8'h80;

  typedef logic [STACK_AW-1:0] sp_t;

  typedef enum logic [2:0] {
    KIND_PHA = 3'd0,
    KIND_PLA = 3'd1,
    KIND_PHP = 3'd2,
    KIND_PLP = 3'd3,
    KIND_RTI = 3'd4
  } kind_t;

  // Microcode address.
  typedef logic [3:0] upc_t;

  localparam upc_t UPC_PHA  = 4'd0;
  localparam upc_t UPC_PHP  = 4'd1;
  localparam upc_t UPC_PLA0 = 4'd2;
  localparam upc_t UPC_PLA1 = 4'd3;
  localparam upc_t UPC_PLP0 = 4'd4;
  localparam upc_t UPC_PLP1 = 4'd5;
  localparam upc_t UPC_RTI0 = 4'd6;
  localparam upc_t UPC_RTI1 = 4'd7;
  localparam upc_t UPC_RTI2 = 4'd8;
  localparam upc_t UPC_RTI3 = 4'd9;
  localparam upc_t UPC_NOP  = 4'd10;

  typedef enum logic {
    WSRC_ACC,
    WSRC_STATUS
  } wsrc_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_ACC,
    CAP_STATUS,
    CAP_PCLO,
    CAP_PCHI
  } cap_t;

  // One control word of the stack program.
  typedef struct packed {
    logic  wr;    // push: write page at pointer, then decrement
    wsrc_t wsrc;
    logic  rd;    // pull: increment pointer, read page there
    cap_t  cap;   // where the byte read by the previous step goes
    logic  fin;   // last step, hands the result to the output register
    upc_t  next;
  } ctl_t;

  // Request from the sequencer to the stack page.
  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STACK_AW-1:0] raddr;
  } ram_req_t;

  function automatic upc_t entry_of(input logic [2:0] kind);
    upc_t e;
    e = UPC_NOP;
    case (kind_t'(kind))
      KIND_PHA: e = UPC_PHA;
      KIND_PLA: e = UPC_PLA0;
      KIND_PHP: e = UPC_PHP;
      KIND_PLP: e = UPC_PLP0;
      KIND_RTI: e = UPC_RTI0;
      default:  e = UPC_NOP;
    endcase
    return e;
  endfunction

  function automatic ctl_t ucode(input upc_t upc);
    ctl_t c;
    c = '{wr: 1'b0, wsrc: WSRC_ACC, rd: 1'b0, cap: CAP_NONE, fin: 1'b1, next: UPC_NOP};
    case (upc)
      UPC_PHA:  c = '{wr: 1'b1, wsrc: WSRC_ACC,    rd: 1'b0, cap: CAP_NONE,
                      fin: 1'b1, next: UPC_NOP};
      UPC_PHP:  c = '{wr: 1'b1, wsrc: WSRC_STATUS, rd: 1'b0, cap: CAP_NONE,
                      fin: 1'b1, next: UPC_NOP};
      UPC_PLA0: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b1, cap: CAP_NONE,
                      fin: 1'b0, next: UPC_PLA1};
      UPC_PLA1: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b0, cap: CAP_ACC,
                      fin: 1'b1, next: UPC_NOP};
      UPC_PLP0: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b1, cap: CAP_NONE,
                      fin: 1'b0, next: UPC_PLP1};
      UPC_PLP1: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b0, cap: CAP_STATUS,
                      fin: 1'b1, next: UPC_NOP};
      UPC_RTI0: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b1, cap: CAP_NONE,
                      fin: 1'b0, next: UPC_RTI1};
      UPC_RTI1: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b1, cap: CAP_STATUS,
                      fin: 1'b0, next: UPC_RTI2};
      UPC_RTI2: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b1, cap: CAP_PCLO,
                      fin: 1'b0, next: UPC_RTI3};
      UPC_RTI3: c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b0, cap: CAP_PCHI,
                      fin: 1'b1, next: UPC_NOP};
      default:  c = '{wr: 1'b0, wsrc: WSRC_ACC,    rd: 1'b0, cap: CAP_NONE,
                      fin: 1'b1, next: UPC_NOP};
    endcase
    return c;
  endfunction

endpackage

[src/csi_in_if.sv]
interface csi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] acc_in;
  logic [7:0] status_in;

  modport source (output valid, output kind, output acc_in, output status_in, input ready);
  modport sink   (input valid, input kind, input acc_in, input status_in, output ready);
endinterface

[src/csi_out_if.sv]
interface csi_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [7:0]  status_out;
  logic [15:0] pc_out;
  logic        pc_valid;
  logic [7:0]  stack_ptr_out;

  modport source (output valid, output acc_out, output status_out, output pc_out,
                  output pc_valid, output stack_ptr_out, input ready);
  modport sink   (input valid, input acc_out, input status_out, input pc_out,
                  input pc_valid, input stack_ptr_out, output ready);
endinterface

[src/csi_stack_ram.sv]
module csi_stack_ram (
  input  logic               clk,
  input  logic               rst_n,
  input  csi_pkg::ram_req_t  req,
  output logic [7:0]         rdata
);

  logic [7:0]                       mem_r [csi_pkg::STACK_DEPTH];
  logic [csi_pkg::STACK_DEPTH-1:0]  vld_r;
  logic [7:0]                       rd_r;
  logic                             rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= mem_r[req.raddr];
    end
  end

  // A byte never pushed since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r <= vld_r[req.raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : 8'h00;

endmodule

[src/cpu_stack_instruction_unit.sv]
// Stack instruction unit: PHA, PLA, PHP, PLP and RTI against an internal 256-byte stack page.
// PHA, PHP and unused kinds finish in a single push or no-op step; PLA and PLP read a byte
// and then capture it; RTI reads the status and the low and high PC bytes and captures each in
// turn. One instruction is in flight, so a new one is taken only after the previous one has
// finished. The stack page moves one byte per microcode step.
// Reset (rst_n low, synchronous) sets the pointer to 0xFD and clears the page valid bits.
module cpu_stack_instruction_unit (
  input  logic      clk,
  input  logic      rst_n,
  csi_in_if.sink    in_ch,
  csi_out_if.source out_ch
);

  // Sequencer state. busy_r is high while a microprogram runs; upc_r is the step counter.
  logic            busy_r, busy_nxt;
  csi_pkg::upc_t   upc_r, upc_nxt;
  csi_pkg::sp_t    sp_r, sp_nxt;

  // Working copies of the instruction's operands and results.
  logic [7:0]      acc_r, acc_nxt;
  logic [7:0]      st_r, st_nxt;
  logic [15:0]     pc_r, pc_nxt;
  logic            pcv_r, pcv_nxt;

  // Result register, which decouples the sequencer from the consumer.
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_acc_r, out_st_r, out_sp_r;
  logic [15:0]     out_pc_r;
  logic            out_pcv_r;

  csi_pkg::ctl_t     ctl;
  csi_pkg::ram_req_t ram_req;
  logic [7:0]        rd_byte;
  logic              accept;
  logic              out_free;
  logic              step_en;
  logic              load_out;

  assign ctl      = csi_pkg::ucode(upc_r);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  // The last step of a program waits until the result register can take its result.
  assign step_en  = busy_r && (!ctl.fin || out_free);
  assign load_out = step_en && ctl.fin;

  assign in_ch.ready = !busy_r;

  // The stack page: a push writes at the pointer, a pull reads one above it.
  always_comb begin
    ram_req.we    = step_en && ctl.wr;
    ram_req.waddr = sp_r;
    ram_req.wdata = (ctl.wsrc == csi_pkg::WSRC_ACC) ? acc_r
                  : (st_r | csi_pkg::BIT_BREAK | csi_pkg::BIT_UNUSED);
    ram_req.re    = step_en && ctl.rd;
    ram_req.raddr = sp_r + csi_pkg::sp_t'(1);
  end

  csi_stack_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (rd_byte)
  );

  // Datapath driven by the current control word. The byte read in one step is
  // captured in the next, while that step may already issue the following read.
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    sp_nxt   = sp_r;
    acc_nxt  = acc_r;
    st_nxt   = st_r;
    pc_nxt   = pc_r;
    pcv_nxt  = pcv_r;
    if (accept) begin
      busy_nxt = 1'b1;
      upc_nxt  = csi_pkg::entry_of(in_ch.kind);
      acc_nxt  = in_ch.acc_in;
      st_nxt   = in_ch.status_in;
      pc_nxt   = 16'h0000;
      pcv_nxt  = (in_ch.kind == csi_pkg::KIND_RTI);
    end else if (step_en) begin
      upc_nxt = ctl.next;
      if (ctl.fin) begin
        busy_nxt = 1'b0;
      end
      if (ctl.wr) begin
        sp_nxt = sp_r - csi_pkg::sp_t'(1);
      end else if (ctl.rd) begin
        sp_nxt = sp_r + csi_pkg::sp_t'(1);
      end
      unique case (ctl.cap)
        csi_pkg::CAP_NONE: begin
        end
        csi_pkg::CAP_ACC: begin
          acc_nxt = rd_byte;
          st_nxt  = (st_r & ~(csi_pkg::BIT_ZERO | csi_pkg::BIT_NEG))
                  | ((rd_byte == 8'h00) ? csi_pkg::BIT_ZERO : 8'h00)
                  | (rd_byte[7] ? csi_pkg::BIT_NEG : 8'h00);
        end
        csi_pkg::CAP_STATUS: begin
          st_nxt = rd_byte & ~(csi_pkg::BIT_BREAK | csi_pkg::BIT_UNUSED);
        end
        csi_pkg::CAP_PCLO: begin
          pc_nxt[7:0] = rd_byte;
        end
        csi_pkg::CAP_PCHI: begin
          pc_nxt[15:8] = rd_byte;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= csi_pkg::UPC_NOP;
      sp_r        <= csi_pkg::SP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operand and result payload carries no reset.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    st_r  <= st_nxt;
    pc_r  <= pc_nxt;
    pcv_r <= pcv_nxt;
    if (load_out) begin
      out_acc_r <= acc_nxt;
      out_st_r  <= st_nxt;
      out_pc_r  <= pc_nxt;
      out_pcv_r <= pcv_nxt;
      out_sp_r  <= 8'(sp_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.acc_out       = out_acc_r;
  assign out_ch.status_out    = out_st_r;
  assign out_ch.pc_out        = out_pc_r;
  assign out_ch.pc_valid      = out_pcv_r;
  assign out_ch.stack_ptr_out = out_sp_r;

  // A finishing step that is blocked by a full result register holds its place.
  a_fin_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctl.fin && out_valid_r && !out_ch.ready) |=> (busy_r && $stable(upc_r)))
    else $error("finishing step advanced while the result register was full");

  // The pointer moves only in a step that pushes or pulls.
  a_sp_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && (ctl.wr || ctl.rd)) |=> $stable(sp_r))
    else $error("stack pointer changed outside a push or pull step");

  // No instruction is taken while a microprogram is running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept)
    else $error("instruction accepted while the sequencer was busy");

  // A result without a pulled program counter reports zero.
  a_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pcv_r) |-> (out_pc_r == 16'h0000))
    else $error("program counter nonzero on a result without a pulled counter");

endmodule
